### rtl/tll_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tll_pkg
// Types, codes and keyword tables shared by the TINY lexer files.
// ----------------------------------------------------------------------------
package tll_pkg;

    localparam int MAX_LINE_COLUMNS = 4096;
    localparam int KEYWORD_MAX_LEN  = 6;
    localparam int NUM_KEYWORDS     = 8;

    localparam logic [11:0] SAT_LIMIT =
        12'(((MAX_LINE_COLUMNS - 1) < 4095) ? (MAX_LINE_COLUMNS - 1) : 4095);

    typedef enum logic [4:0] {
        TK_IF     = 5'd0,
        TK_THEN   = 5'd1,
        TK_ELSE   = 5'd2,
        TK_END    = 5'd3,
        TK_REPEAT = 5'd4,
        TK_UNTIL  = 5'd5,
        TK_READ   = 5'd6,
        TK_WRITE  = 5'd7,
        TK_ID     = 5'd8,
        TK_NUM    = 5'd9,
        TK_ASSIGN = 5'd10,
        TK_EQ     = 5'd11,
        TK_LT     = 5'd12,
        TK_PLUS   = 5'd13,
        TK_MINUS  = 5'd14,
        TK_TIMES  = 5'd15,
        TK_OVER   = 5'd16,
        TK_LPAREN = 5'd17,
        TK_RPAREN = 5'd18,
        TK_SEMI   = 5'd19,
        TK_ERROR  = 5'd20,
        TK_EOL    = 5'd21
    } t_token_kind;

    typedef enum logic [2:0] {
        SCAN_IDLE    = 3'd0,
        SCAN_COMMENT = 3'd1,
        SCAN_IDENT   = 3'd2,
        SCAN_NUMBER  = 3'd3,
        SCAN_COLON   = 3'd4
    } t_scan_mode;

    typedef struct packed {
        t_token_kind kind;
        logic [11:0] start;
        logic [11:0] length;
        logic [7:0]  err;
        logic        last;
    } t_token;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Strings are written backwards so that the first letter sits in byte lane 0.
    localparam logic [47:0] KW_TEXT [NUM_KEYWORDS] = '{
        48'("fi"), 48'("neht"), 48'("esle"), 48'("dne"),
        48'("taeper"), 48'("litnu"), 48'("daer"), 48'("etirw")
    };
    localparam logic [2:0] KW_LEN [NUM_KEYWORDS] = '{
        3'd2, 3'd4, 3'd4, 3'd3, 3'd6, 3'd5, 3'd4, 3'd5
    };

    function automatic logic [11:0] sat_inc(input logic [11:0] v);
        return (v < SAT_LIMIT) ? (v + 12'd1) : SAT_LIMIT;
    endfunction

endpackage

### rtl/tll_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tll_char_if / tll_token_if
// Valid/ready channels for source characters and scanned tokens.
// ----------------------------------------------------------------------------
interface tll_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       line_end;

    modport source (output valid, output char_byte, output line_end, input ready);
    modport sink   (input valid, input char_byte, input line_end, output ready);
endinterface

interface tll_token_if;
    logic        valid;
    logic        ready;
    logic [4:0]  token_kind;
    logic [11:0] start_column;
    logic [11:0] token_length;
    logic [7:0]  error_char;
    logic        last_of_run;

    modport source (output valid, output token_kind, output start_column,
                    output token_length, output error_char, output last_of_run,
                    input ready);
    modport sink   (input valid, input token_kind, input start_column,
                    input token_length, input error_char, input last_of_run,
                    output ready);
    modport monitor (input valid, input ready, input token_kind, input start_column,
                     input token_length, input error_char, input last_of_run);
endinterface

### rtl/tiny_language_lexer_top.sv
`timescale 1ns / 1ps
// Output: each token is written into the 4-entry token queue on the clock edge that
//   takes the character beat that produced it, and o_token is driven from that queue.
// Throughput: one character beat per cycle while the token queue holds two or fewer
//   entries; a beat that yields two tokens leaves them one at a time at the single token port.
// Reset (i_rst_n low, synchronous): scan mode idle, column and lexeme counters
//   zero, token queue empty. The identifier byte buffer is not reset.
// ----------------------------------------------------------------------------
// tiny_language_lexer_top
// Streaming scanner for the TINY language, one source byte per beat.
// ----------------------------------------------------------------------------
module tiny_language_lexer_top
    import tll_pkg::*;
#(
    parameter int KW_MAX_LEN = KEYWORD_MAX_LEN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tll_char_if.sink    i_char,
    tll_token_if.source o_token
);

    localparam int FILL_W = $clog2(KW_MAX_LEN + 1);
    localparam int IDX_W  = $clog2(KW_MAX_LEN);
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // scan state
    t_scan_mode        r_mode, n_mode;
    logic [FILL_W-1:0] r_fill, n_fill;
    logic [11:0]       r_start, n_start;
    logic [11:0]       r_length, n_length;
    logic [11:0]       r_column, n_column;
    logic [7:0]        r_word [KW_MAX_LEN];

    // result queue
    t_token            r_queue [QDEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QCNT_W-1:0] r_count, n_count;

    logic              accept, pop;
    logic [7:0]        ch;
    logic              ch_alpha, ch_digit, ch_space;
    t_token_kind       word_kind, sym_kind;
    t_token            flush_tok, scan_tok, res0, res1;
    logic              flush_hit, scan_hit;
    logic [1:0]        res_n;
    logic              word_we;
    logic [IDX_W-1:0]  word_idx;

    assign accept       = i_char.valid & i_char.ready;
    assign i_char.ready = (r_count <= QCNT_W'(QDEPTH - 2));
    assign pop          = o_token.valid & o_token.ready;

    assign ch       = i_char.char_byte;
    assign ch_alpha = (ch >= 8'h61 && ch <= 8'h7A) || (ch >= 8'h41 && ch <= 8'h5A);
    assign ch_digit = (ch >= 8'h30 && ch <= 8'h39);
    assign ch_space = (ch == CH_SPACE) || (ch >= 8'h09 && ch <= 8'h0D);

    // keyword match on the buffered identifier; lanes past the keyword length are ignored
    always_comb begin
        logic hit;
        word_kind = TK_ID;
        for (int k = NUM_KEYWORDS - 1; k >= 0; k--) begin
            hit = (FILL_W'(KW_LEN[k]) == r_fill) && (r_length == 12'(r_fill));
            for (int i = 0; i < 6; i++) begin
                hit = hit && ((i >= int'(KW_LEN[k])) || (r_word[i] == KW_TEXT[k][8*i +: 8]));
            end
            if (hit) begin
                word_kind = t_token_kind'(5'(k));
            end
        end
    end

    always_comb begin
        unique case (ch)
            CH_EQ:     sym_kind = TK_EQ;
            CH_LT:     sym_kind = TK_LT;
            CH_PLUS:   sym_kind = TK_PLUS;
            CH_MINUS:  sym_kind = TK_MINUS;
            CH_STAR:   sym_kind = TK_TIMES;
            CH_SLASH:  sym_kind = TK_OVER;
            CH_LPAREN: sym_kind = TK_LPAREN;
            CH_RPAREN: sym_kind = TK_RPAREN;
            CH_SEMI:   sym_kind = TK_SEMI;
            default:   sym_kind = TK_ERROR;
        endcase
    end

    // token pending in the current mode
    always_comb begin
        flush_tok = '{kind: TK_ID, start: r_start, length: r_length, err: 8'h00, last: 1'b0};
        flush_hit = 1'b0;
        unique case (r_mode)
            SCAN_IDENT: begin
                flush_tok.kind = word_kind;
                flush_hit      = 1'b1;
            end
            SCAN_NUMBER: begin
                flush_tok.kind = TK_NUM;
                flush_hit      = 1'b1;
            end
            SCAN_COLON: begin
                flush_tok.kind   = TK_ERROR;
                flush_tok.length = 12'd1;
                flush_tok.err    = CH_COLON;
                flush_hit        = 1'b1;
            end
            default: begin
                flush_hit = 1'b0;
            end
        endcase
    end

    always_comb begin
        logic do_flush, do_scan, do_eol, do_assign;
        t_token eol_tok, asg_tok;

        n_mode   = r_mode;
        n_fill   = r_fill;
        n_start  = r_start;
        n_length = r_length;
        n_column = r_column;
        word_we  = 1'b0;
        word_idx = r_fill[IDX_W-1:0];
        scan_tok = '{kind: sym_kind, start: r_column, length: 12'd1,
                     err: (sym_kind == TK_ERROR) ? ch : 8'h00, last: 1'b0};
        scan_hit = 1'b0;
        eol_tok  = '{kind: TK_EOL, start: r_column, length: 12'd0, err: 8'h00, last: 1'b0};
        asg_tok  = '{kind: TK_ASSIGN, start: r_start, length: 12'd2, err: 8'h00, last: 1'b0};
        do_flush  = 1'b0;
        do_scan   = 1'b0;
        do_eol    = 1'b0;
        do_assign = 1'b0;

        if (accept) begin
            if (i_char.line_end) begin
                do_flush = 1'b1;
                do_eol   = 1'b1;
                n_mode   = SCAN_IDLE;
                n_column = 12'd0;
            end else begin
                n_column = sat_inc(r_column);
                unique case (r_mode)
                    SCAN_COMMENT: begin
                        if (ch == CH_RBRACE) begin
                            n_mode = SCAN_IDLE;
                        end
                    end
                    SCAN_IDENT: begin
                        if (ch_alpha || ch_digit) begin
                            if (r_fill < FILL_W'(KW_MAX_LEN)) begin
                                word_we = 1'b1;
                                n_fill  = r_fill + FILL_W'(1);
                            end
                            n_length = sat_inc(r_length);
                        end else begin
                            do_flush = 1'b1;
                            do_scan  = 1'b1;
                        end
                    end
                    SCAN_NUMBER: begin
                        if (ch_digit) begin
                            n_length = sat_inc(r_length);
                        end else begin
                            do_flush = 1'b1;
                            do_scan  = 1'b1;
                        end
                    end
                    SCAN_COLON: begin
                        if (ch == CH_EQ) begin
                            do_assign = 1'b1;
                            n_mode    = SCAN_IDLE;
                        end else begin
                            do_flush = 1'b1;
                            do_scan  = 1'b1;
                        end
                    end
                    default: begin
                        do_scan = 1'b1;
                    end
                endcase
            end
        end

        if (do_scan) begin
            n_mode = SCAN_IDLE;
            priority if (ch_space) begin
                n_mode = SCAN_IDLE;
            end else if (ch == CH_LBRACE) begin
                n_mode = SCAN_COMMENT;
            end else if (ch_alpha || ch_digit || ch == CH_COLON) begin
                n_start  = r_column;
                n_length = 12'd1;
                if (ch == CH_COLON) begin
                    n_mode = SCAN_COLON;
                end else if (ch_alpha) begin
                    n_mode   = SCAN_IDENT;
                    word_we  = 1'b1;
                    word_idx = '0;
                    n_fill   = FILL_W'(1);
                end else begin
                    n_mode = SCAN_NUMBER;
                end
            end else begin
                scan_hit = 1'b1;
            end
        end

        // gather up to two results in order
        res_n = 2'd0;
        res0  = flush_tok;
        res1  = eol_tok;
        if (do_flush && flush_hit) begin
            res0  = flush_tok;
            res_n = 2'd1;
        end
        if (do_eol) begin
            if (res_n == 2'd0) res0 = eol_tok; else res1 = eol_tok;
            res_n = res_n + 2'd1;
        end
        if (scan_hit) begin
            if (res_n == 2'd0) res0 = scan_tok; else res1 = scan_tok;
            res_n = res_n + 2'd1;
        end
        if (do_assign) begin
            res0  = asg_tok;
            res_n = 2'd1;
        end
        if (res_n == 2'd1) res0.last = 1'b1;
        if (res_n == 2'd2) res1.last = 1'b1;

        n_count = r_count + QCNT_W'(res_n) - QCNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= SCAN_IDLE;
            r_fill   <= '0;
            r_start  <= '0;
            r_length <= '0;
            r_column <= '0;
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_mode   <= n_mode;
            r_fill   <= n_fill;
            r_start  <= n_start;
            r_length <= n_length;
            r_column <= n_column;
            r_wr_ptr <= r_wr_ptr + QPTR_W'(res_n);
            r_rd_ptr <= r_rd_ptr + QPTR_W'(pop);
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (word_we) begin
            r_word[word_idx] <= ch;
        end
        if (res_n != 2'd0) begin
            r_queue[r_wr_ptr] <= res0;
        end
        if (res_n == 2'd2) begin
            r_queue[r_wr_ptr + QPTR_W'(1)] <= res1;
        end
    end

    assign o_token.valid        = (r_count != '0);
    assign o_token.token_kind   = r_queue[r_rd_ptr].kind;
    assign o_token.start_column = r_queue[r_rd_ptr].start;
    assign o_token.token_length = r_queue[r_rd_ptr].length;
    assign o_token.error_char   = r_queue[r_rd_ptr].err;
    assign o_token.last_of_run  = r_queue[r_rd_ptr].last;

endmodule

### rtl/tll_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tll_checker
// Port-level checks on the token stream of the TINY lexer.
// ----------------------------------------------------------------------------
module tll_checker
    import tll_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        i_ready,
    input logic [4:0]  i_token_kind,
    input logic [11:0] i_start_column,
    input logic [11:0] i_token_length,
    input logic [7:0]  i_error_char,
    input logic        i_last_of_run
);

    // queue empties on reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_valid)
        else $error("token valid right after reset");

    a_eol_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind == TK_EOL
            |-> i_last_of_run && i_token_length == 12'd0)
        else $error("end-of-line token not last or nonzero length");

    a_err_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && i_token_kind != TK_ERROR |-> i_error_char == 8'h00)
        else $error("error byte on a non-error token");

    a_kind_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> i_token_kind <= TK_EOL)
        else $error("token kind out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !i_ready
            |=> i_valid && $stable(i_token_kind)
                && $stable(i_start_column) && $stable(i_token_length)
                && $stable(i_error_char) && $stable(i_last_of_run))
        else $error("stalled token beat changed");

endmodule

bind tiny_language_lexer_top tll_checker u_tll_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (o_token.valid),
    .i_ready        (o_token.ready),
    .i_token_kind   (o_token.token_kind),
    .i_start_column (o_token.start_column),
    .i_token_length (o_token.token_length),
    .i_error_char   (o_token.error_char),
    .i_last_of_run  (o_token.last_of_run)
);
